// ----- hdl/slom_pkg.sv -----
`default_nettype none
package slom_pkg;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_LENS_SIZE     = 2'd0,
		REG_SCREEN_WIDTH  = 2'd1,
		REG_OUTLINE_WIDTH = 2'd2,
		REG_DISTORTION    = 2'd3
	} reg_idx_t;

	localparam logic [10:0] MAX_LENS         = 11'd1024;
	localparam logic [12:0] MAX_SCREEN_WIDTH = 13'd4096;
	localparam int          FRAC_BITS        = 16;
	localparam logic [16:0] ONE              = 17'h10000;
	localparam logic [16:0] RHO_MAX          = 17'h0FFFF;
	// round(0.0001 * 2^16)
	localparam logic [16:0] RHO_MIN          = 17'd7;
	localparam logic [23:0] OFFSET_MAX       = 24'hFFFFFF;

	// First divider: q * k / m^2, one quotient bit per cell.
	localparam int D1_R = 21;
	localparam int D1_N = 17;
	// Square root of t * 2^16, one result bit per cell.
	localparam int SQ_RR  = 19;
	localparam int SQ_QW  = 17;
	localparam int SQ_RB  = 34;
	localparam int SQ_N   = SQ_RB / 2;
	// Second divider: rho * 2^16 / st.
	localparam int D2_R = 17;
	localparam int D2_N = 16;

	// Per-pixel values that ride along with the arithmetic.
	typedef struct packed {
		logic               in_lens;
		logic [23:0]        straight;
		logic signed [12:0] ix2;
		logic signed [12:0] iy2;
	} tag_t;

	localparam int TAG_W = $bits(tag_t);

endpackage
`default_nettype wire

// ----- hdl/slom_div_cell.sv -----
`default_nettype none
module slom_div_cell #(
	parameter int R  = 21,
	parameter int N  = 17,
	parameter int TW = 51
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_i,
	input  logic [TW-1:0] tag_i,
	input  logic [R-1:0]  rem_i,
	input  logic [N-1:0]  low_i,
	input  logic [R-1:0]  div_i,
	output logic          v_q,
	output logic [TW-1:0] tag_q,
	output logic [R-1:0]  rem_q,
	output logic [N-1:0]  low_q,
	output logic [R-1:0]  div_q
);

	logic [R:0] sh;
	logic [R:0] diff;
	logic       ge;

	// Restoring step: bring in the next dividend bit, the quotient bit
	// replaces it at the bottom of the low word.
	assign sh   = {rem_i, low_i[N-1]};
	assign ge   = sh >= {1'b0, div_i};
	assign diff = sh - {1'b0, div_i};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_q <= tag_i;
			rem_q <= ge ? diff[R-1:0] : sh[R-1:0];
			low_q <= {low_i[N-2:0], ge};
			div_q <= div_i;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/slom_sqrt_cell.sv -----
`default_nettype none
module slom_sqrt_cell #(
	parameter int RR = 19,
	parameter int QW = 17,
	parameter int RB = 34,
	parameter int TW = 52
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_i,
	input  logic [TW-1:0] tag_i,
	input  logic [RR-1:0] rem_i,
	input  logic [QW-1:0] root_i,
	input  logic [RB-1:0] rad_i,
	output logic          v_q,
	output logic [TW-1:0] tag_q,
	output logic [RR-1:0] rem_q,
	output logic [QW-1:0] root_q,
	output logic [RB-1:0] rad_q
);

	localparam int PAD = RR - QW;

	logic [RR+1:0] ext;
	logic [RR+1:0] trial;
	logic [RR+1:0] diff;
	logic          ge;

	// Digit-by-digit root: two radicand bits in, one root bit out.
	assign ext   = {rem_i, rad_i[RB-1:RB-2]};
	assign trial = {{PAD{1'b0}}, root_i, 2'b01};
	assign ge    = ext >= trial;
	assign diff  = ext - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_q  <= tag_i;
			rem_q  <= ge ? diff[RR-1:0] : ext[RR-1:0];
			root_q <= {root_i[QW-2:0], ge};
			rad_q  <= {rad_i[RB-3:0], 2'b00};
		end
	end

endmodule
`default_nettype wire

// ----- hdl/spherical_lens_offset_map.sv -----
`default_nettype none
// Spherical lens offset map.
// Input stream: one lens-local pixel per transaction on s_tvalid/s_tready,
// s_tdata carries pos_x in bits 9:0 and pos_y in bits 19:10.
// Output stream: one transaction per input on m_tvalid/m_tready, m_tdata is
// the 24-bit byte offset of the source pixel and m_tuser is the inside-lens
// flag.
// Throughput is one pixel per clock while the output does not stall. An
// accepted pixel passes four front stages, a row of 17 divider cells for
// q*k/m^2, 17 square-root cells, 16 divider cells for u, three back stages
// and the output register, the first of them loaded at the accepting edge.
// Configuration is a write enable, a register index and 16 bits of data; the
// user must write it while no pixel is in flight; the block does not enforce it.
// Reset clears all valid flags and loads the register defaults; the derived
// lens constants settle through rho_q, rho_sq_q and k_q before pixels need them.
// When the receiver stalls, the output register holds and one more result
// lands in a skid register; only then does s_tready drop and the whole row
// of cells hold.
module spherical_lens_offset_map (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // pos_x, pos_y, zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // source_offset
	output logic [0:0]  m_tuser,   // inside_lens
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_data
);

	localparam int TW  = slom_pkg::TAG_W;
	localparam int TW2 = slom_pkg::TAG_W + 1;

	// Configuration registers.
	logic [10:0] lens_size_q;
	logic [12:0] screen_width_q;
	logic [5:0]  outline_width_q;
	logic [15:0] distortion_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lens_size_q     <= 11'd144;
			screen_width_q  <= 13'd640;
			outline_width_q <= 6'd2;
			distortion_q    <= 16'd57344;
		end else if (cfg_wen) begin
			unique case (slom_pkg::reg_idx_t'(cfg_idx))
				slom_pkg::REG_LENS_SIZE:     lens_size_q     <= cfg_data[10:0];
				slom_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data[12:0];
				slom_pkg::REG_OUTLINE_WIDTH: outline_width_q <= cfg_data[5:0];
				slom_pkg::REG_DISTORTION:    distortion_q    <= cfg_data;
			endcase
		end
	end

	// Derived lens constants.
	logic [10:0]        l_eff;
	logic [12:0]        w_eff;
	logic signed [12:0] m_c;
	logic signed [25:0] m_sq;
	logic [16:0]        rho_raw;
	logic [16:0]        rho_hi;
	logic [16:0]        rho_c;
	logic [15:0]        rho_q;
	logic [31:0]        rho_sq_q;
	logic [16:0]        k_q;
	logic [20:0]        m2_q;

	assign l_eff   = (lens_size_q > slom_pkg::MAX_LENS) ? slom_pkg::MAX_LENS : lens_size_q;
	assign w_eff   = (screen_width_q > slom_pkg::MAX_SCREEN_WIDTH) ?
		slom_pkg::MAX_SCREEN_WIDTH : screen_width_q;
	assign m_c     = $signed({2'b00, l_eff}) - $signed({5'b0, outline_width_q, 2'b00});
	assign m_sq    = m_c * m_c;
	assign rho_raw = slom_pkg::ONE - {1'b0, distortion_q};
	assign rho_hi  = (rho_raw > slom_pkg::RHO_MAX) ? slom_pkg::RHO_MAX : rho_raw;
	assign rho_c   = (rho_hi < slom_pkg::RHO_MIN) ? slom_pkg::RHO_MIN : rho_hi;

	always_ff @(posedge clk) begin
		rho_q    <= rho_c[15:0];
		rho_sq_q <= rho_q * rho_q;
		k_q      <= slom_pkg::ONE - {1'b0, rho_sq_q[31:16]};
		m2_q     <= m_sq[20:0];
	end

	// Flow control: every stage before the output register moves unless the skid register is occupied.
	logic adv;
	logic out_v_q;
	logic skid_v_q;

	assign adv      = !skid_v_q;
	assign s_tready = adv;

	// Front stages.
	logic               v_s1, v_s2, v_s3, v_s4;
	logic [9:0]         x_s1, y_s1, x_s2;
	logic signed [12:0] ix2_s1, iy2_s1, ix2_s2, iy2_s2;
	logic [23:0]        xsq_s2, ysq_s2;
	logic [22:0]        yw_s2;
	logic signed [25:0] xsq_full, ysq_full;
	logic [24:0]        q_sum;
	logic [21:0]        straight_pix;
	logic [19:0]        q_s3;
	slom_pkg::tag_t     tag_s3, tag_s4;
	logic [36:0]        num_s4;

	assign xsq_full     = ix2_s1 * ix2_s1;
	assign ysq_full     = iy2_s1 * iy2_s1;
	assign q_sum        = {1'b0, xsq_s2} + {1'b0, ysq_s2};
	assign straight_pix = yw_s2[21:0] + {12'b0, x_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1   <= s_tdata[9:0];
			y_s1   <= s_tdata[19:10];
			ix2_s1 <= $signed({2'b00, s_tdata[9:0], 1'b0}) - $signed({2'b00, l_eff}) + 13'sd2;
			iy2_s1 <= $signed({2'b00, s_tdata[19:10], 1'b0}) - $signed({2'b00, l_eff}) + 13'sd2;

			xsq_s2 <= xsq_full[23:0];
			ysq_s2 <= ysq_full[23:0];
			yw_s2  <= y_s1 * w_eff;
			x_s2   <= x_s1;
			ix2_s2 <= ix2_s1;
			iy2_s2 <= iy2_s1;

			q_s3             <= q_sum[19:0];
			tag_s3.in_lens   <= q_sum < {4'b0, m2_q};
			tag_s3.straight  <= {straight_pix, 2'b00};
			tag_s3.ix2       <= ix2_s2;
			tag_s3.iy2       <= iy2_s2;

			num_s4 <= q_s3 * k_q;
			tag_s4 <= tag_s3;
		end
	end

	// Row of divider cells for q*k/m^2.
	logic                       d1_v   [0:slom_pkg::D1_N];
	logic [TW-1:0]              d1_tag [0:slom_pkg::D1_N];
	logic [slom_pkg::D1_R-1:0]  d1_rem [0:slom_pkg::D1_N];
	logic [slom_pkg::D1_N-1:0]  d1_low [0:slom_pkg::D1_N];
	logic [slom_pkg::D1_R-1:0]  d1_div [0:slom_pkg::D1_N];

	assign d1_v[0]   = v_s4;
	assign d1_tag[0] = tag_s4;
	assign d1_rem[0] = {1'b0, num_s4[36:17]};
	assign d1_low[0] = num_s4[16:0];
	assign d1_div[0] = m2_q;

	for (genvar i = 0; i < slom_pkg::D1_N; i++) begin : g_d1
		slom_div_cell #(.R(slom_pkg::D1_R), .N(slom_pkg::D1_N), .TW(TW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.v_i(d1_v[i]), .tag_i(d1_tag[i]), .rem_i(d1_rem[i]),
			.low_i(d1_low[i]), .div_i(d1_div[i]),
			.v_q(d1_v[i+1]), .tag_q(d1_tag[i+1]), .rem_q(d1_rem[i+1]),
			.low_q(d1_low[i+1]), .div_q(d1_div[i+1])
		);
	end

	// Row of square-root cells for sqrt(t * 2^16).
	logic [16:0]                 t_c;
	logic                        sq_v    [0:slom_pkg::SQ_N];
	logic [TW-1:0]               sq_tag  [0:slom_pkg::SQ_N];
	logic [slom_pkg::SQ_RR-1:0]  sq_rem  [0:slom_pkg::SQ_N];
	logic [slom_pkg::SQ_QW-1:0]  sq_root [0:slom_pkg::SQ_N];
	logic [slom_pkg::SQ_RB-1:0]  sq_rad  [0:slom_pkg::SQ_N];

	assign t_c        = slom_pkg::ONE - d1_low[slom_pkg::D1_N];
	assign sq_v[0]    = d1_v[slom_pkg::D1_N];
	assign sq_tag[0]  = d1_tag[slom_pkg::D1_N];
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_rad[0]  = {1'b0, t_c, 16'b0};

	for (genvar i = 0; i < slom_pkg::SQ_N; i++) begin : g_sq
		slom_sqrt_cell #(
			.RR(slom_pkg::SQ_RR), .QW(slom_pkg::SQ_QW), .RB(slom_pkg::SQ_RB), .TW(TW)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.v_i(sq_v[i]), .tag_i(sq_tag[i]), .rem_i(sq_rem[i]),
			.root_i(sq_root[i]), .rad_i(sq_rad[i]),
			.v_q(sq_v[i+1]), .tag_q(sq_tag[i+1]), .rem_q(sq_rem[i+1]),
			.root_q(sq_root[i+1]), .rad_q(sq_rad[i+1])
		);
	end

	// Row of divider cells for u = rho * 2^16 / st. When rho >= st the
	// quotient would reach one, so u saturates and the flag rides along.
	logic [slom_pkg::SQ_QW-1:0] st_c;
	logic                       d2_v   [0:slom_pkg::D2_N];
	logic [TW2-1:0]             d2_tag [0:slom_pkg::D2_N];
	logic [slom_pkg::D2_R-1:0]  d2_rem [0:slom_pkg::D2_N];
	logic [slom_pkg::D2_N-1:0]  d2_low [0:slom_pkg::D2_N];
	logic [slom_pkg::D2_R-1:0]  d2_div [0:slom_pkg::D2_N];

	assign st_c      = sq_root[slom_pkg::SQ_N];
	assign d2_v[0]   = sq_v[slom_pkg::SQ_N];
	assign d2_tag[0] = {({1'b0, rho_q} >= st_c), sq_tag[slom_pkg::SQ_N]};
	assign d2_rem[0] = {1'b0, rho_q};
	assign d2_low[0] = '0;
	assign d2_div[0] = st_c;

	for (genvar i = 0; i < slom_pkg::D2_N; i++) begin : g_d2
		slom_div_cell #(.R(slom_pkg::D2_R), .N(slom_pkg::D2_N), .TW(TW2)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.v_i(d2_v[i]), .tag_i(d2_tag[i]), .rem_i(d2_rem[i]),
			.low_i(d2_low[i]), .div_i(d2_div[i]),
			.v_q(d2_v[i+1]), .tag_q(d2_tag[i+1]), .rem_q(d2_rem[i+1]),
			.low_q(d2_low[i+1]), .div_q(d2_div[i+1])
		);
	end

	// Back stages: u * ix2 and u * iy2, centering and floor, row times screen width.
	slom_pkg::tag_t     tag_d2, tag_s5, tag_s6, tag_s7;
	logic               sat_d2;
	logic [15:0]        u_c;
	logic               v_s5, v_s6, v_s7;
	logic signed [29:0] uxp_s5, uyp_s5;
	logic signed [11:0] lm2;
	logic signed [30:0] base_c;
	logic signed [30:0] sx_c, sy_c;
	logic signed [13:0] px_s6, py_s6, px_s7;
	logic signed [27:0] pyw_s7;

	assign tag_d2 = d2_tag[slom_pkg::D2_N][TW-1:0];
	assign sat_d2 = d2_tag[slom_pkg::D2_N][TW];
	assign u_c    = sat_d2 ? slom_pkg::RHO_MAX[15:0] : d2_low[slom_pkg::D2_N];
	assign lm2    = $signed({1'b0, l_eff}) - 12'sd2;
	assign base_c = {{3{lm2[11]}}, lm2, 16'b0};
	assign sx_c   = base_c + {{1{uxp_s5[29]}}, uxp_s5};
	assign sy_c   = base_c + {{1{uyp_s5[29]}}, uyp_s5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s5 <= d2_v[slom_pkg::D2_N];
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			uxp_s5 <= $signed({1'b0, u_c}) * tag_d2.ix2;
			uyp_s5 <= $signed({1'b0, u_c}) * tag_d2.iy2;
			tag_s5 <= tag_d2;

			// Arithmetic shift gives the floor for negative sums too.
			px_s6  <= sx_c[30:17];
			py_s6  <= sy_c[30:17];
			tag_s6 <= tag_s5;

			pyw_s7 <= py_s6 * $signed({1'b0, w_eff});
			px_s7  <= px_s6;
			tag_s7 <= tag_s6;
		end
	end

	// Offset with saturation.
	logic signed [29:0] tot_c;
	logic [23:0]        lens_off;
	logic [23:0]        res_off;

	assign tot_c = {{2{pyw_s7[27]}}, pyw_s7} + {{16{px_s7[13]}}, px_s7};

	always_comb begin
		priority if (tot_c < 30'sd0) begin
			lens_off = '0;
		end else if (tot_c > $signed({8'b0, slom_pkg::OFFSET_MAX[23:2]})) begin
			lens_off = slom_pkg::OFFSET_MAX;
		end else begin
			lens_off = {tot_c[21:0], 2'b00};
		end
	end

	assign res_off = tag_s7.in_lens ? lens_off : tag_s7.straight;

	// Output register and skid register.
	logic [23:0] out_off_q, skid_off_q;
	logic        out_in_q, skid_in_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q || m_tready) begin
				if (skid_v_q) begin
					out_v_q   <= 1'b1;
					out_off_q <= skid_off_q;
					out_in_q  <= skid_in_q;
					skid_v_q  <= 1'b0;
				end else begin
					out_v_q   <= v_s7;
					out_off_q <= res_off;
					out_in_q  <= tag_s7.in_lens;
				end
			end else if (adv && v_s7) begin
				skid_v_q   <= 1'b1;
				skid_off_q <= res_off;
				skid_in_q  <= tag_s7.in_lens;
			end
		end
	end

	assign m_tvalid   = out_v_q;
	assign m_tdata    = out_off_q;
	assign m_tuser[0] = out_in_q;

	// The skid register only ever fills behind a full output register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register holds a result while the output is empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !m_tready && v_s7))
		else $error("skid register filled without a stalled output");

	a_drain_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && m_tready) |=> (out_v_q && !skid_v_q))
		else $error("skid register not moved to the output");

endmodule
`default_nettype wire

// ----- sim/spherical_lens_offset_map_test.sv -----
`timescale 1ns / 1ps
module spherical_lens_offset_map_test;

	localparam int HOLD_LEN = 300;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // pos_x, pos_y, zero fill
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // source_offset
	logic [0:0]  m_tuser;   // inside_lens
	logic        cfg_wen;
	logic [1:0]  cfg_idx;
	logic [15:0] cfg_data;

	spherical_lens_offset_map uut (.*);

	typedef struct packed {
		logic [23:0] offset;
		logic        in_lens;
	} map_entry_t;

	map_entry_t  expected_map[$];
	int          error_count = 0;
	longint      cycle_count = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          hold_cycles = 0;
	int          hold_reqs = 0;
	int          hold_seen = 0;

	// Shadow copies of the configuration registers.
	longint      cur_lens, cur_screen, cur_outline, cur_distortion;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 600000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic longint int_sqrt(longint v);
		longint r, b;
		r = 0;
		b = 64'sh1 << 62;
		while (b > v) b = b >>> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic longint floor_div_pow2(longint n, int s);
		if (n >= 0) return n >>> s;
		return -((-n + (64'sh1 << s) - 1) >>> s);
	endfunction

	function automatic longint clamp_offset(longint v);
		if (v < 0) return 0;
		if (v > 16777215) return 16777215;
		return v;
	endfunction

	function automatic map_entry_t predict_map(logic [9:0] px_in, logic [9:0] py_in);
		map_entry_t e;
		longint l, w, m, m2, x, y, ix2, iy2, q, rho, k, t, st, u, px, py, one;
		one = 64'sh1 << slom_pkg::FRAC_BITS;
		l = (cur_lens > 1024) ? 1024 : cur_lens;
		w = (cur_screen > 4096) ? 4096 : cur_screen;
		m = l - 4 * cur_outline;
		m2 = m * m;
		x = px_in;
		y = py_in;
		ix2 = 2 * x - l + 2;
		iy2 = 2 * y - l + 2;
		q = ix2 * ix2 + iy2 * iy2;
		if (q < m2) begin
			rho = one - cur_distortion;
			if (rho > one - 1) rho = one - 1;
			if (rho < 7) rho = 7;
			k = one - ((rho * rho) >>> slom_pkg::FRAC_BITS);
			t = one - (q * k) / m2;
			st = int_sqrt(t << slom_pkg::FRAC_BITS);
			if (st == 0) st = 1;
			u = (rho << slom_pkg::FRAC_BITS) / st;
			if (u > one - 1) u = one - 1;
			px = floor_div_pow2((l - 2) * one + u * ix2, slom_pkg::FRAC_BITS + 1);
			py = floor_div_pow2((l - 2) * one + u * iy2, slom_pkg::FRAC_BITS + 1);
			e.offset = clamp_offset((py * w + px) * 4);
			e.in_lens = 1'b1;
		end else begin
			e.offset = clamp_offset((y * w + x) * 4);
			e.in_lens = 1'b0;
		end
		return e;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
		error_count++;
	endtask

	// Output side: random back-pressure, plus a long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_reqs != hold_seen) begin
			hold_seen <= hold_reqs;
			hold_cycles <= HOLD_LEN;
			m_tready <= 1'b0;
		end else if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		map_entry_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_map.size() == 0) begin
				report_mismatch("unexpected transaction", m_tdata, 0);
			end else begin
				e = expected_map.pop_front();
				if (m_tdata !== e.offset) report_mismatch("source_offset", m_tdata, e.offset);
				if (m_tuser[0] !== e.in_lens) report_mismatch("inside_lens", m_tuser, e.in_lens);
			end
		end
	end

	task automatic send_pixel(int x, int y);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, 10'(y), 10'(x)};
		expected_map.push_back(predict_map(10'(x), 10'(y)));
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (expected_map.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(slom_pkg::reg_idx_t idx, longint val);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val[15:0];
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			slom_pkg::REG_LENS_SIZE: cur_lens = val & 16'h7FF;
			slom_pkg::REG_SCREEN_WIDTH: cur_screen = val & 16'h1FFF;
			slom_pkg::REG_OUTLINE_WIDTH: cur_outline = val & 16'h3F;
			default: cur_distortion = val & 16'hFFFF;
		endcase
	endtask

	task automatic configure(longint l, longint w, longint o, longint d);
		wait_drain();
		write_reg(slom_pkg::REG_LENS_SIZE, l);
		write_reg(slom_pkg::REG_SCREEN_WIDTH, w);
		write_reg(slom_pkg::REG_OUTLINE_WIDTH, o);
		write_reg(slom_pkg::REG_DISTORTION, d);
	endtask

	task automatic test_directed();
		send_pixel(0, 0);
		send_pixel(1023, 1023);
		send_pixel(71, 71);
		send_pixel(72, 70);
		send_pixel(0, 1023);
		send_pixel(1023, 0);
		send_pixel(10'h2AA, 10'h155);
		send_pixel(10'h155, 10'h2AA);
		// Oversized lens and screen, tiny rho.
		configure(2047, 8191, 0, 65535);
		send_pixel(511, 511);
		send_pixel(0, 0);
		send_pixel(1023, 1023);
		send_pixel(300, 700);
		// Empty sphere.
		configure(8, 640, 2, 1);
		send_pixel(3, 3);
		send_pixel(0, 0);
		// Negative m, smallest nonzero distortion.
		configure(40, 1, 63, 1);
		send_pixel(19, 19);
		send_pixel(0, 0);
		send_pixel(1023, 1023);
		// Zero distortion: rho clamps below one.
		configure(1, 4096, 0, 0);
		send_pixel(0, 0);
		send_pixel(1, 0);
	endtask

	task automatic test_random(int n, int l_max);
		int x, y;
		int lim;
		configure($urandom_range(l_max, 1), $urandom_range(4096, 1),
			$urandom_range(l_max > 252 ? 63 : l_max / 4), $urandom_range(65535, 1));
		lim = (cur_lens > 1024) ? 1023 : int'(cur_lens) - 1;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) < 8) begin
				x = $urandom_range(lim);
				y = $urandom_range(lim);
			end else begin
				x = $urandom_range(1023);
				y = $urandom_range(1023);
			end
			send_pixel(x, y);
		end
	endtask

	task automatic test_backpressure();
		configure(144, 640, 2, 57344);
		send_idle_pct = 0;
		hold_reqs++;
		for (int i = 0; i < 120; i++) send_pixel($urandom_range(143), $urandom_range(143));
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_wen = 1'b0;
		cfg_idx = slom_pkg::REG_LENS_SIZE;
		cfg_data = '0;
		cur_lens = 144;
		cur_screen = 640;
		cur_outline = 2;
		cur_distortion = 57344;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (5) @(posedge clk);
		test_directed();
		send_idle_pct = 31;
		recv_idle_pct = 66;
		for (int p = 0; p < 6; p++) test_random(100, p == 0 ? 1024 : 200);
		send_idle_pct = 66;
		recv_idle_pct = 31;
		for (int p = 0; p < 6; p++) test_random(100, p == 0 ? 2047 : 200);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int p = 0; p < 6; p++) test_random(100, 300);
		test_backpressure();
		wait_drain();
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
